@@ rtl/pvr_pkg.sv @@
// Package: shared constants and types for the page replacement policy unit.
package pvr_pkg;

    // Frame storage geometry
    localparam int NUM_FRAMES = 16;
    localparam int PAGE_BITS  = 16;
    localparam int FRAME_W    = $clog2(NUM_FRAMES);
    localparam int CNT_W      = $clog2(NUM_FRAMES + 1);

    // Field widths
    localparam int STAMP_W = 32;
    localparam int USE_W   = 16;
    localparam int FAULT_W = 32;
    localparam int POL_W   = 2;
    localparam int FIL_W   = 5;
    localparam int CMP_W   = (CNT_W > FIL_W) ? CNT_W : FIL_W;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_POLICY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAMES = 2'd1;

    // Replacement policy codes; the unused code falls back to LRU
    localparam logic [POL_W-1:0] POL_LRU  = 2'd0;
    localparam logic [POL_W-1:0] POL_FIFO = 2'd1;
    localparam logic [POL_W-1:0] POL_LFU  = 2'd2;

    localparam logic [FIL_W-1:0] FRAMES_RST = FIL_W'(NUM_FRAMES);

    // Control sequence
    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SCAN   = 3'b010,
        S_COMMIT = 3'b100
    } t_state;

    // Probe word that walks down the row of frame cells
    typedef struct packed {
        logic                 valid;
        logic [PAGE_BITS-1:0] page;
        logic                 found;
        logic [FRAME_W-1:0]   hit_idx;
        logic                 free_seen;
        logic [FRAME_W-1:0]   free_idx;
        logic                 best_seen;
        logic [STAMP_W-1:0]   best_key;
        logic [FRAME_W-1:0]   best_idx;
        logic [PAGE_BITS-1:0] best_page;
    } t_probe;

    // Update command broadcast to all cells
    typedef struct packed {
        logic                 en;
        logic                 fill;
        logic [FRAME_W-1:0]   idx;
        logic [PAGE_BITS-1:0] page;
        logic [STAMP_W-1:0]   stamp;
    } t_upd;

endpackage

@@ rtl/pvr_if.sv @@
// Interfaces: page reference input, result output and configuration write channels.
interface pvr_in_if import pvr_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [PAGE_BITS-1:0] page;

    modport source (output valid, output page, input ready);
    modport sink   (input valid, input page, output ready);
endinterface

interface pvr_out_if import pvr_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic                 hit;
    logic [FRAME_W-1:0]   frame_index;
    logic                 used_free_frame;
    logic                 replaced;
    logic [PAGE_BITS-1:0] evicted_page;
    logic [FAULT_W-1:0]   fault_total;

    modport source (output valid, output hit, output frame_index, output used_free_frame,
                    output replaced, output evicted_page, output fault_total, input ready);
    modport sink   (input valid, input hit, input frame_index, input used_free_frame,
                    input replaced, input evicted_page, input fault_total, output ready);
endinterface

interface pvr_cfg_if import pvr_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/pvr_cell.sv @@
// Frame cell: holds one frame and merges its match, free and victim data into the probe word.
module pvr_cell import pvr_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [FRAME_W-1:0] i_idx,
    input  logic [CNT_W-1:0]   i_n,
    input  logic [POL_W-1:0]   i_policy,
    input  t_probe             i_probe,
    input  t_upd               i_upd,
    output t_probe             o_probe
);

    logic                 r_valid;
    logic [PAGE_BITS-1:0] r_page;
    logic [STAMP_W-1:0]   r_recency;
    logic [STAMP_W-1:0]   r_arrival;
    logic [USE_W-1:0]     r_use;
    t_probe               r_probe;
    t_probe               n_probe;
    logic [STAMP_W-1:0]   w_key;
    logic                 w_active;
    logic                 w_sel;

    // Pick the victim key for the configured policy
    always_comb begin
        case (i_policy)
            POL_FIFO: w_key = r_arrival;
            POL_LFU:  w_key = STAMP_W'(r_use);
            default:  w_key = r_recency;
        endcase
    end

    assign w_active = (CNT_W'(i_idx) < i_n);
    assign w_sel    = i_upd.en && (i_upd.idx == i_idx);

    // Merge this frame into the passing probe word; earlier frames win ties
    always_comb begin
        n_probe = i_probe;
        if (w_active) begin
            if (r_valid && (r_page == i_probe.page) && !i_probe.found) begin
                n_probe.found   = 1'b1;
                n_probe.hit_idx = i_idx;
            end
            if (!r_valid && !i_probe.free_seen) begin
                n_probe.free_seen = 1'b1;
                n_probe.free_idx  = i_idx;
            end
            if (r_valid && (!i_probe.best_seen || (w_key < i_probe.best_key))) begin
                n_probe.best_seen = 1'b1;
                n_probe.best_key  = w_key;
                n_probe.best_idx  = i_idx;
                n_probe.best_page = r_page;
            end
        end
    end

    // Advance the probe word to the next cell
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_probe <= '0;
        end else begin
            r_probe <= n_probe;
        end
    end

    assign o_probe = r_probe;

    // Frame valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_sel && i_upd.fill) begin
            r_valid <= 1'b1;
        end
    end

    // Frame contents: fill on a fault, refresh on a hit
    always_ff @(posedge i_clk) begin
        if (w_sel) begin
            r_recency <= i_upd.stamp;
            if (i_upd.fill) begin
                r_page    <= i_upd.page;
                r_arrival <= i_upd.stamp;
                r_use     <= USE_W'(1);
            end else if (r_use != {USE_W{1'b1}}) begin
                r_use <= r_use + USE_W'(1);
            end
        end
    end

endmodule

@@ rtl/page_replacement_policy.sv @@
// Top level: page replacement unit with a row of frame cells, control sequence and counters.
// An accepted page word walks through the 16 frame cells, is captured in the result
// register and is committed to the output word register; a stalled output word holds
// the commit. A new page word is taken only in idle, after the last one is committed.
// Reset (i_rst_n low, synchronous): all frames invalid, counters zero, policy LRU,
// 16 frames in use; frame contents are not cleared and need no clearing pass.
module page_replacement_policy import pvr_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    pvr_in_if.sink     i_in,
    pvr_out_if.source  o_out,
    pvr_cfg_if.sink    i_cfg
);

    t_state               r_state;
    t_state               n_state;
    logic [POL_W-1:0]     r_policy;
    logic [FIL_W-1:0]     r_frames;
    logic [CNT_W-1:0]     w_n;
    logic [STAMP_W-1:0]   r_access;
    logic [FAULT_W-1:0]   r_fault;
    logic [FAULT_W-1:0]   w_fault_inc;
    t_probe               r_res;
    t_probe               w_launch;
    t_probe               w_chain [NUM_FRAMES+1];
    t_upd                 w_upd;
    logic                 w_accept;
    logic                 w_go;

    logic                 r_out_valid;
    logic                 r_out_hit;
    logic [FRAME_W-1:0]   r_out_idx;
    logic                 r_out_free;
    logic                 r_out_repl;
    logic [PAGE_BITS-1:0] r_out_evict;
    logic [FAULT_W-1:0]   r_out_fault;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = (r_state == S_IDLE);
    assign w_accept    = i_in.valid && (r_state == S_IDLE);
    assign w_go        = (r_state == S_COMMIT) && (!r_out_valid || o_out.ready);

    // Configuration registers; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy <= POL_LRU;
            r_frames <= FRAMES_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_POLICY: r_policy <= i_cfg.data[POL_W-1:0];
                CFG_FRAMES: r_frames <= i_cfg.data[FIL_W-1:0];
                default:    ;
            endcase
        end
    end

    // Clamp the frame count to one through NUM_FRAMES
    always_comb begin
        if (r_frames == '0) begin
            w_n = CNT_W'(1);
        end else if (CMP_W'(r_frames) > CMP_W'(NUM_FRAMES)) begin
            w_n = CNT_W'(NUM_FRAMES);
        end else begin
            w_n = CNT_W'(r_frames);
        end
    end

    // Launch a fresh probe word into the first cell
    always_comb begin
        w_launch       = '0;
        w_launch.valid = w_accept;
        w_launch.page  = i_in.page;
    end

    assign w_chain[0] = w_launch;

    // Row of frame cells
    for (genvar g = 0; g < NUM_FRAMES; g++) begin : g_cell
        pvr_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_idx    (FRAME_W'(g)),
            .i_n      (w_n),
            .i_policy (r_policy),
            .i_probe  (w_chain[g]),
            .i_upd    (w_upd),
            .o_probe  (w_chain[g+1])
        );
    end

    // Sequence: idle, wait for the probe to leave the row, commit
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (w_accept) n_state = S_SCAN;
            S_SCAN:   if (w_chain[NUM_FRAMES].valid) n_state = S_COMMIT;
            S_COMMIT: if (w_go) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Hold the scan result for the commit cycle
    always_ff @(posedge i_clk) begin
        if (r_state == S_SCAN && w_chain[NUM_FRAMES].valid) begin
            r_res <= w_chain[NUM_FRAMES];
        end
    end

    // Access counter supplies the stamps; advance it on every accepted word, saturating at all ones
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_access <= '0;
        end else if (w_accept && (r_access != {STAMP_W{1'b1}})) begin
            r_access <= r_access + STAMP_W'(1);
        end
    end

    assign w_fault_inc = (r_fault != {FAULT_W{1'b1}}) ? (r_fault + FAULT_W'(1)) : r_fault;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fault <= '0;
        end else if (w_go && !r_res.found) begin
            r_fault <= w_fault_inc;
        end
    end

    // Update command: refresh on a hit, fill a free frame or the victim on a fault
    always_comb begin
        w_upd.en    = w_go;
        w_upd.fill  = !r_res.found;
        w_upd.page  = r_res.page;
        w_upd.stamp = r_access;
        if (r_res.found) begin
            w_upd.idx = r_res.hit_idx;
        end else if (r_res.free_seen) begin
            w_upd.idx = r_res.free_idx;
        end else begin
            w_upd.idx = r_res.best_idx;
        end
    end

    // Output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_go) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_go) begin
            r_out_hit   <= r_res.found;
            r_out_idx   <= w_upd.idx;
            r_out_free  <= !r_res.found && r_res.free_seen;
            r_out_repl  <= !r_res.found && !r_res.free_seen;
            r_out_evict <= (!r_res.found && !r_res.free_seen) ? r_res.best_page : '0;
            r_out_fault <= r_res.found ? r_fault : w_fault_inc;
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.hit             = r_out_hit;
    assign o_out.frame_index     = r_out_idx;
    assign o_out.used_free_frame = r_out_free;
    assign o_out.replaced        = r_out_repl;
    assign o_out.evicted_page    = r_out_evict;
    assign o_out.fault_total     = r_out_fault;

`ifndef SYNTHESIS
    a_probe_exit_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_chain[NUM_FRAMES].valid |-> (r_state == S_SCAN))
        else $error("probe left the cell row outside the scan phase");

    a_result_after_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out.valid) |-> $past(r_state == S_COMMIT))
        else $error("result word appeared without a commit");

    a_hit_keeps_faults: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_go && r_res.found) |=> $stable(r_fault))
        else $error("fault counter moved on a hit");
`endif

endmodule

@@ bench/tb_page_replacement_policy.sv @@
// Testbench: page replacement policy unit, directed table then random phases, self-checking.
`timescale 1ns / 1ps

module tb_page_replacement_policy;
    import pvr_pkg::*;

    localparam int NUM_PHASES      = 16;
    localparam int WORDS_PER_PHASE = 100;
    localparam int QUIET_PHASES    = 2;
    localparam int POOL_DEPTH      = 24;
    localparam int DRAIN_CYCLES    = 40;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int REPORT_LIMIT    = 10;

    // Register indexes past the end of the map and the spare policy code
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;
    localparam logic [POL_W-1:0]     POL_SPARE   = 2'd3;

    localparam logic [FIL_W-1:0] FRAME_PICKS [6] = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd2, 5'd17};

    typedef struct packed {
        logic                 hit;
        logic [FRAME_W-1:0]   frame_index;
        logic                 used_free_frame;
        logic                 replaced;
        logic [PAGE_BITS-1:0] evicted_page;
        logic [FAULT_W-1:0]   fault_total;
    } t_page_outcome;

    typedef enum logic [1:0] {
        ROW_CFG,
        ROW_REF,
        ROW_REF_KNOWN
    } t_row_kind;

    typedef struct packed {
        t_row_kind             kind;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] reg_data;
        logic [PAGE_BITS-1:0]  page;
        t_page_outcome         want;
    } t_stim_row;

    localparam int NUM_ROWS = 25;

    // Directed table; outcomes typed in only where they are obvious
    localparam t_stim_row DIRECTED [NUM_ROWS] = '{
        '{ROW_REF_KNOWN, CFG_POLICY,  8'h00, 16'h0000, '{1'b0, 4'd0, 1'b1, 1'b0, 16'h0000, 32'd1}},
        '{ROW_REF_KNOWN, CFG_POLICY,  8'h00, 16'hFFFF, '{1'b0, 4'd1, 1'b1, 1'b0, 16'h0000, 32'd2}},
        '{ROW_REF_KNOWN, CFG_POLICY,  8'h00, 16'h0000, '{1'b1, 4'd0, 1'b0, 1'b0, 16'h0000, 32'd2}},
        '{ROW_CFG,       CFG_FRAMES,  8'h02, 16'h0000, '0},
        '{ROW_REF,       CFG_POLICY,  8'h00, 16'h1234, '0},
        '{ROW_CFG,       CFG_POLICY,  8'h01, 16'h0000, '0},
        '{ROW_REF,       CFG_POLICY,  8'h00, 16'hABCD, '0},
        '{ROW_CFG,       CFG_POLICY,  8'h02, 16'h0000, '0},
        '{ROW_REF,       CFG_POLICY,  8'h00, 16'h1234, '0},
        '{ROW_REF,       CFG_POLICY,  8'h00, 16'h5555, '0},
        '{ROW_CFG,       CFG_POLICY,  8'hFF, 16'h0000, '0},
        '{ROW_REF,       CFG_POLICY,  8'h00, 16'hAAAA, '0},
        '{ROW_CFG,       CFG_FRAMES,  8'hE0, 16'h0000, '0},
        '{ROW_REF,       CFG_POLICY,  8'h00, 16'h0F0F, '0},
        '{ROW_REF,       CFG_POLICY,  8'h00, 16'h0F0F, '0},
        '{ROW_REF,       CFG_POLICY,  8'h00, 16'hAAAA, '0},
        '{ROW_CFG,       CFG_FRAMES,  8'h3F, 16'h0000, '0},
        '{ROW_REF,       CFG_POLICY,  8'h00, 16'hAAAA, '0},
        '{ROW_REF,       CFG_POLICY,  8'h00, 16'h8001, '0},
        '{ROW_CFG,       CFG_SPARE_A, 8'h55, 16'h0000, '0},
        '{ROW_CFG,       CFG_SPARE_B, 8'hAA, 16'h0000, '0},
        '{ROW_REF,       CFG_POLICY,  8'h00, 16'h8001, '0},
        '{ROW_REF,       CFG_POLICY,  8'h00, 16'h7FFE, '0},
        '{ROW_CFG,       CFG_POLICY,  8'h00, 16'h0000, '0},
        '{ROW_CFG,       CFG_FRAMES,  8'h10, 16'h0000, '0}
    };

    logic clk;
    logic rst_n;

    pvr_in_if  pg_in();
    pvr_out_if res_out();
    pvr_cfg_if cfg_bus();

    page_replacement_policy dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (pg_in),
        .o_out   (res_out),
        .i_cfg   (cfg_bus)
    );

    // Frame table mirror and register copies
    logic [PAGE_BITS-1:0] fr_page   [NUM_FRAMES];
    logic                 fr_valid  [NUM_FRAMES];
    logic [STAMP_W-1:0]   fr_recent [NUM_FRAMES];
    logic [STAMP_W-1:0]   fr_arrive [NUM_FRAMES];
    logic [USE_W-1:0]     fr_uses   [NUM_FRAMES];
    logic [STAMP_W-1:0]   ref_count;
    logic [FAULT_W-1:0]   miss_count;
    logic [POL_W-1:0]     cfg_policy;
    logic [FIL_W-1:0]     cfg_frames;

    t_page_outcome pending_outcomes[$];

    bit idling_on;
    int cycles;
    int mismatches;
    int words_sent;
    int results_seen;
    int hits_seen;
    int fills_seen;
    int evictions_seen;
    int writes_done;

    // Work out the outcome of one page reference and advance the mirror
    function automatic t_page_outcome resolve_reference(input logic [PAGE_BITS-1:0] pg);
        t_page_outcome      res;
        int                 span;
        int                 slot;
        bit                 found;
        bit                 free_seen;
        logic [STAMP_W-1:0] best;
        logic [STAMP_W-1:0] key;
        res  = '0;
        span = (cfg_frames == 0) ? 1 : ((cfg_frames > NUM_FRAMES) ? NUM_FRAMES : int'(cfg_frames));
        if (ref_count != '1) ref_count++;
        found = 1'b0;
        slot  = 0;
        for (int f = 0; f < span; f++) begin
            if (!found && fr_valid[f] && fr_page[f] == pg) begin
                found = 1'b1;
                slot  = f;
            end
        end
        if (found) begin
            res.hit = 1'b1;
            fr_recent[slot] = ref_count;
            if (fr_uses[slot] != '1) fr_uses[slot]++;
        end else begin
            free_seen = 1'b0;
            for (int f = 0; f < span; f++) begin
                if (!free_seen && !fr_valid[f]) begin
                    free_seen = 1'b1;
                    slot      = f;
                end
            end
            if (free_seen) begin
                res.used_free_frame = 1'b1;
            end else begin
                // Smallest key wins, lowest index on a tie
                best = '0;
                for (int f = 0; f < span; f++) begin
                    case (cfg_policy)
                        POL_FIFO: key = fr_arrive[f];
                        POL_LFU:  key = STAMP_W'(fr_uses[f]);
                        default:  key = fr_recent[f];
                    endcase
                    if (f == 0 || key < best) begin
                        best = key;
                        slot = f;
                    end
                end
                res.replaced     = 1'b1;
                res.evicted_page = fr_page[slot];
            end
            if (miss_count != '1) miss_count++;
            fr_page[slot]   = pg;
            fr_valid[slot]  = 1'b1;
            fr_recent[slot] = ref_count;
            fr_arrive[slot] = ref_count;
            fr_uses[slot]   = USE_W'(1);
        end
        res.frame_index = FRAME_W'(slot);
        res.fault_total = miss_count;
        return res;
    endfunction

    // Clock
    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Run-time guard
    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, pending_outcomes.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    // Result side: random stall bursts while idling is on
    initial begin : result_drain
        int stall_left;
        stall_left    = 0;
        res_out.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (stall_left > 0) begin
                res_out.ready = 1'b0;
                stall_left--;
            end else if (idling_on && $urandom_range(0, 4) == 0) begin
                res_out.ready = 1'b0;
                stall_left    = $urandom_range(0, 2);
            end else begin
                res_out.ready = 1'b1;
            end
        end
    end

    // Compare each result word against the oldest expectation
    always @(posedge clk) begin
        t_page_outcome want;
        t_page_outcome got;
        if (rst_n && res_out.valid && res_out.ready) begin
            got = '{res_out.hit, res_out.frame_index, res_out.used_free_frame,
                    res_out.replaced, res_out.evicted_page, res_out.fault_total};
            results_seen++;
            if (pending_outcomes.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected result word %0d: hit=%0d frame=%0d", results_seen,
                             got.hit, got.frame_index);
            end else begin
                want = pending_outcomes.pop_front();
                if (got.hit) hits_seen++;
                if (got.used_free_frame) fills_seen++;
                if (got.replaced) evictions_seen++;
                if (got != want) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display({"result %0d mismatch: expected hit=%0d frame=%0d free=%0d ",
                                  "repl=%0d evicted=%h faults=%0d, got hit=%0d frame=%0d ",
                                  "free=%0d repl=%0d evicted=%h faults=%0d"},
                                 results_seen, want.hit, want.frame_index, want.used_free_frame,
                                 want.replaced, want.evicted_page, want.fault_total,
                                 got.hit, got.frame_index, got.used_free_frame,
                                 got.replaced, got.evicted_page, got.fault_total);
                end
            end
        end
    end

    // Drop valid and hold until every outstanding result has arrived
    task automatic wait_drained();
        @(negedge clk);
        pg_in.valid = 1'b0;
        while (pending_outcomes.size() != 0) @(posedge clk);
    endtask

    // Write one register while the block is idle
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        wait_drained();
        @(negedge clk);
        cfg_bus.valid = 1'b1;
        cfg_bus.index = idx;
        cfg_bus.data  = data;
        @(posedge clk);
        while (!(cfg_bus.valid && cfg_bus.ready)) @(posedge clk);
        if (idx == CFG_POLICY) cfg_policy = data[POL_W-1:0];
        else if (idx == CFG_FRAMES) cfg_frames = data[FIL_W-1:0];
        writes_done++;
        @(negedge clk);
        cfg_bus.valid = 1'b0;
    endtask

    // Send one page word; keep valid high across back-to-back words
    task automatic send_page(input logic [PAGE_BITS-1:0] pg, input bit known,
                             input t_page_outcome want);
        int            gap;
        t_page_outcome predicted;
        gap = (idling_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
        @(negedge clk);
        if (gap > 0) begin
            pg_in.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        pg_in.valid = 1'b1;
        pg_in.page  = pg;
        @(posedge clk);
        while (!(pg_in.valid && pg_in.ready)) @(posedge clk);
        predicted = resolve_reference(pg);
        pending_outcomes.push_back(known ? want : predicted);
        words_sent++;
    endtask

    initial begin : stimulus
        logic [PAGE_BITS-1:0] pool [POOL_DEPTH];
        logic [FIL_W-1:0]     frm_pick;
        logic [POL_W-1:0]     pol_pick;
        logic [PAGE_BITS-1:0] pg;
        int                   work_set;
        int                   span;

        pg_in.valid   = 1'b0;
        pg_in.page    = '0;
        cfg_bus.valid = 1'b0;
        cfg_bus.index = CFG_POLICY;
        cfg_bus.data  = '0;
        idling_on     = 1'b0;
        rst_n         = 1'b0;

        // Mirror of the reset state
        for (int f = 0; f < NUM_FRAMES; f++) begin
            fr_page[f]   = '0;
            fr_valid[f]  = 1'b0;
            fr_recent[f] = '0;
            fr_arrive[f] = '0;
            fr_uses[f]   = '0;
        end
        ref_count  = '0;
        miss_count = '0;
        cfg_policy = POL_LRU;
        cfg_frames = FRAMES_RST;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed table
        idling_on = 1'b1;
        for (int r = 0; r < NUM_ROWS; r++) begin
            case (DIRECTED[r].kind)
                ROW_CFG:       write_register(DIRECTED[r].reg_idx, DIRECTED[r].reg_data);
                ROW_REF_KNOWN: send_page(DIRECTED[r].page, 1'b1, DIRECTED[r].want);
                default:       send_page(DIRECTED[r].page, 1'b0, '0);
            endcase
        end

        // Random phases: new settings, a working set of pages, some noise
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            pol_pick = (ph < 4) ? POL_W'(ph) : POL_W'($urandom_range(0, 3));
            frm_pick = (ph < 6) ? FRAME_PICKS[ph] : FIL_W'($urandom_range(0, 31));
            if ($urandom_range(0, 1) == 0) begin
                write_register(CFG_POLICY, {6'($urandom), pol_pick});
                write_register(CFG_FRAMES, {3'($urandom), frm_pick});
            end else begin
                write_register(CFG_FRAMES, {3'($urandom), frm_pick});
                write_register(CFG_POLICY, {6'($urandom), pol_pick});
            end
            if ($urandom_range(0, 3) == 0)
                write_register($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B, 8'($urandom));

            idling_on = (ph < NUM_PHASES - QUIET_PHASES) && ($urandom_range(0, 3) != 0);
            span = (frm_pick == 0) ? 1 : ((frm_pick > NUM_FRAMES) ? NUM_FRAMES : int'(frm_pick));
            work_set = $urandom_range(1, span + 6);
            if (work_set > POOL_DEPTH) work_set = POOL_DEPTH;
            for (int k = 0; k < POOL_DEPTH; k++) pool[k] = PAGE_BITS'($urandom);

            for (int w = 0; w < WORDS_PER_PHASE; w++) begin
                if ($urandom_range(0, 99) < 85) begin
                    // Skew toward the front of the pool so use counts spread apart
                    if ($urandom_range(0, 1) == 0)
                        pg = pool[$urandom_range(0, (work_set + 1) / 2 - 1)];
                    else
                        pg = pool[$urandom_range(0, work_set - 1)];
                end else begin
                    pg = PAGE_BITS'($urandom);
                end
                send_page(pg, 1'b0, '0);
            end
        end

        // Let the tail drain, then watch for stray words
        idling_on = 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display({"covered %0d page words in %0d random phases: ",
                  "%0d hits, %0d free fills, %0d evictions"},
                 words_sent, NUM_PHASES, hits_seen, fills_seen, evictions_seen);
        $display({"%0d register writes over LRU, FIFO, LFU, the spare code ",
                  "and frame counts 0..31; %0d mismatches"},
                 writes_done, mismatches);
        if (mismatches == 0 && pending_outcomes.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

@@ page_replacement_policy.f @@
rtl/pvr_pkg.sv
rtl/pvr_if.sv
rtl/pvr_cell.sv
rtl/page_replacement_policy.sv
bench/tb_page_replacement_policy.sv
